/* rtl/lcdtc_pkg.sv */
// Shared types and constants for the character display text console.
// Used by every module of the block; depends on nothing.
package lcdtc_pkg;

	// Item command codes
	typedef enum logic {
		CmdPutChar = 1'b0,
		CmdSetLine = 1'b1
	} cmd_t;

	// Character codes
	localparam logic [7:0] NewlineCode  = 8'h0A;
	localparam logic [7:0] PrintableMin = 8'h1B;

	// Display controller instructions
	localparam logic [7:0] InstrClear = 8'h01;
	localparam logic [7:0] RowAddr0   = 8'h80 | 8'h00;
	localparam logic [7:0] RowAddr1   = 8'h80 | 8'h40;
	localparam logic [7:0] RowAddr2   = 8'h80 | 8'h14;
	localparam logic [7:0] RowAddr3   = 8'h80 | 8'h54;

	// Character count marks
	localparam logic [6:0] CountRow0  = 7'd0;
	localparam logic [6:0] CountRow1  = 7'd20;
	localparam logic [6:0] CountRow2  = 7'd40;
	localparam logic [6:0] CountRow3  = 7'd60;
	localparam logic [6:0] CountLimit = 7'd80;

	// Line selector values
	localparam logic [2:0] LineFirst   = 3'd1;
	localparam logic [3:0] LineWrapMin = 4'd5;

	// Default depth of the queue between front and back
	localparam int DefaultQueueDepth = 4;

	// One display write
	typedef struct packed {
		logic       is_data;
		logic [7:0] bus_byte;
	} lcd_write_t;

	// Writes caused by one item: one or two
	typedef struct packed {
		logic       two;
		lcd_write_t w0;
		lcd_write_t w1;
	} lcd_entry_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

/* rtl/lcdtc_front.sv */
// Front of the text console: accepts items, keeps line selector and count,
// and turns each character into zero, one or two display writes. Uses lcdtc_pkg.
module lcdtc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic [7:0]          char_code,
	input  logic [2:0]          line_value,
	input  lcdtc_pkg::q_status_t q_stat,
	output logic                push,
	output lcdtc_pkg::lcd_entry_t push_entry
);
	import lcdtc_pkg::*;

	logic [2:0]  line_select_q;
	logic [6:0]  char_count_q;
	logic [2:0]  sel_n;
	logic [6:0]  cnt_n;
	logic [3:0]  sel_inc;
	logic [1:0]  n_wr;
	lcd_write_t  w0;
	lcd_write_t  w1;
	logic        accept;

	// Hold off items while the queue has no room
	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;

	// Classify the item and build its writes
	always_comb begin
		sel_n   = line_select_q;
		cnt_n   = char_count_q;
		sel_inc = '0;
		n_wr    = '0;
		w0      = '0;
		w1      = '0;
		if (cmd == CmdSetLine) begin
			sel_n = line_value;
		end else begin
			// newline: row address for the selected line, then advance
			if (char_code == NewlineCode) begin
				unique case (line_select_q)
					3'd0: begin
						w0 = '{is_data: 1'b0, bus_byte: RowAddr0};
						n_wr = 2'd1;
						cnt_n = CountRow0;
					end
					3'd1: begin
						w0 = '{is_data: 1'b0, bus_byte: RowAddr1};
						n_wr = 2'd1;
						cnt_n = CountRow1;
					end
					3'd2: begin
						w0 = '{is_data: 1'b0, bus_byte: RowAddr2};
						n_wr = 2'd1;
						cnt_n = CountRow2;
					end
					3'd3: begin
						w0 = '{is_data: 1'b0, bus_byte: RowAddr3};
						n_wr = 2'd1;
						cnt_n = CountRow3;
					end
					default: begin
					end
				endcase
				sel_inc = {1'b0, line_select_q} + 4'd1;
				if (sel_inc >= LineWrapMin) begin
					sel_n = LineFirst;
					// row address and clear never come together here
					w0 = '{is_data: 1'b0, bus_byte: InstrClear};
					n_wr = 2'd1;
				end else begin
					sel_n = sel_inc[2:0];
				end
			end
			// force row addresses at count marks, clear past the count limit
			priority if (cnt_n == CountRow1) begin
				if (n_wr == 2'd0) w0 = '{is_data: 1'b0, bus_byte: RowAddr1};
				else              w1 = '{is_data: 1'b0, bus_byte: RowAddr1};
				n_wr = n_wr + 2'd1;
			end else if (cnt_n == CountRow2) begin
				if (n_wr == 2'd0) w0 = '{is_data: 1'b0, bus_byte: RowAddr2};
				else              w1 = '{is_data: 1'b0, bus_byte: RowAddr2};
				n_wr = n_wr + 2'd1;
			end else if (cnt_n == CountRow3) begin
				if (n_wr == 2'd0) w0 = '{is_data: 1'b0, bus_byte: RowAddr3};
				else              w1 = '{is_data: 1'b0, bus_byte: RowAddr3};
				n_wr = n_wr + 2'd1;
				cnt_n = CountRow0;
			end else if (cnt_n > CountLimit) begin
				if (n_wr == 2'd0) w0 = '{is_data: 1'b0, bus_byte: InstrClear};
				else              w1 = '{is_data: 1'b0, bus_byte: InstrClear};
				n_wr = n_wr + 2'd1;
				cnt_n = CountRow0;
			end else begin
			end
			// printable code goes out as data
			if (char_code > PrintableMin) begin
				if (n_wr == 2'd0) w0 = '{is_data: 1'b1, bus_byte: char_code};
				else              w1 = '{is_data: 1'b1, bus_byte: char_code};
				n_wr = n_wr + 2'd1;
				cnt_n = cnt_n + 7'd1;
			end
		end
	end

	// Queue an entry only when the item caused writes
	assign push             = accept && (n_wr != 2'd0);
	assign push_entry.two   = n_wr[1];
	assign push_entry.w0    = w0;
	assign push_entry.w1    = w1;

	// Update selector and count on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_select_q <= '0;
			char_count_q  <= '0;
		end else if (accept) begin
			line_select_q <= sel_n;
			char_count_q  <= cnt_n;
		end
	end

endmodule

/* rtl/lcdtc_queue.sv */
// Short queue of write entries between front and back of the text console.
// Uses lcdtc_pkg for the entry and status types.
module lcdtc_queue #(
	parameter int Depth = lcdtc_pkg::DefaultQueueDepth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  lcdtc_pkg::lcd_entry_t push_entry,
	input  logic                  pop,
	output lcdtc_pkg::lcd_entry_t head,
	output lcdtc_pkg::q_status_t  q_stat
);
	import lcdtc_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	lcd_entry_t          mem_q [Depth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                do_push;
	logic                do_pop;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == FullCnt);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

/* rtl/lcdtc_back.sv */
// Back of the text console: drains queued entries one display write a cycle
// into an output register unless stalled. Uses lcdtc_pkg entry/status types.
module lcdtc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lcdtc_pkg::lcd_entry_t head,
	input  lcdtc_pkg::q_status_t  q_stat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  is_data,
	output logic [7:0]            bus_byte,
	output logic                  last
);
	import lcdtc_pkg::*;

	logic       out_valid_q;
	logic       is_data_q;
	logic [7:0] bus_byte_q;
	logic       last_q;
	logic       second_q;
	logic       load;
	lcd_write_t cur;
	logic       cur_last;

	// Output register is free when empty or its word is taken
	assign load     = !q_stat.empty && (!out_valid_q || !out_stall);
	assign cur      = second_q ? head.w1 : head.w0;
	assign cur_last = second_q || !head.two;
	assign pop      = load && cur_last;

	// Track which write of the head entry goes next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				second_q    <= !cur_last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output word
	always_ff @(posedge clk) begin
		if (load) begin
			is_data_q  <= cur.is_data;
			bus_byte_q <= cur.bus_byte;
			last_q     <= cur_last;
		end
	end

	assign out_valid = out_valid_q;
	assign is_data   = is_data_q;
	assign bus_byte  = bus_byte_q;
	assign last      = last_q;

endmodule

/* rtl/char_lcd_text_cursor_top.sv */
// Text console for a 20x4 character display: top level.
// Connects lcdtc_front, lcdtc_queue and lcdtc_back; uses lcdtc_pkg.
//
// Input channel (in_valid/in_stall): one word per item, cmd selects put
// character or load line selector. An item is taken at a clock edge with
// in_valid high and in_stall low. The front decodes a character and updates
// line selector and count in the cycle it is taken, so items can arrive back
// to back as long as the queue has room.
// Output channel (out_valid/out_stall): one display write per word, with
// last marking the final write of an item. An item causes zero, one or two
// writes; the back drains one write per cycle from the queue while the
// receiver does not stall, so a two-write item takes two output words.
// The first write of an item passes through the queue and then the output
// register to the output; the second write follows it there.
// When the receiver stalls, the output word holds, the queue fills, and
// once the queue is full in_stall rises. Reset clears selector, count,
// queue and output valid.
module char_lcd_text_cursor_top #(
	parameter int QueueDepth = lcdtc_pkg::DefaultQueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [7:0] char_code,
	input  logic [2:0] line_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_data,
	output logic [7:0] bus_byte,
	output logic       last
);
	import lcdtc_pkg::*;

	logic       push;
	logic       pop;
	lcd_entry_t push_entry;
	lcd_entry_t head;
	q_status_t  q_stat;

	// Accept and decode items
	lcdtc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.char_code  (char_code),
		.line_value (line_value),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Buffer write entries
	lcdtc_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// Issue display writes
	lcdtc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_data   (is_data),
		.bus_byte  (bus_byte),
		.last      (last)
	);

endmodule

/* tb/sv/tb_char_lcd_text_cursor_top.sv */
// Self-checking bench for the 20x4 text console: drives characters and line
// loads, predicts every display write and checks it word by word.
// Depends on lcdtc_pkg and char_lcd_text_cursor_top.
module tb_char_lcd_text_cursor_top;
	import lcdtc_pkg::*;

	localparam int RandomItems = 1550;
	localparam int IdlePct     = 23;

	// One expected display write
	typedef struct {
		logic       is_data;
		logic [7:0] bus_byte;
		logic       last;
	} lcd_exp_t;

	// Console predictor and store of pending display writes
	class lcd_write_book;
		logic [2:0] line_sel;
		logic [6:0] char_cnt;
		lcd_exp_t   pending_q[$];
		int         mismatches;
		int         items_seen;
		int         data_writes;
		int         instr_writes;

		function new();
			line_sel   = '0;
			char_cnt   = '0;
			mismatches = 0;
			items_seen = 0;
			data_writes  = 0;
			instr_writes = 0;
		endfunction

		function lcd_exp_t mk(logic d, logic [7:0] b);
			lcd_exp_t e;
			e.is_data  = d;
			e.bus_byte = b;
			e.last     = 1'b0;
			return e;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		// Work out the writes that one accepted item causes
		function void note_item(cmd_t c, logic [7:0] ch, logic [2:0] lv);
			lcd_exp_t   w[$];
			logic [3:0] next_sel;
			items_seen++;
			if (c == CmdSetLine) begin
				line_sel = lv;
				return;
			end
			// newline: row address for the selected line, then advance
			if (ch == NewlineCode) begin
				case (line_sel)
					3'd0: begin
						w.push_back(mk(1'b0, RowAddr0));
						char_cnt = CountRow0;
					end
					3'd1: begin
						w.push_back(mk(1'b0, RowAddr1));
						char_cnt = CountRow1;
					end
					3'd2: begin
						w.push_back(mk(1'b0, RowAddr2));
						char_cnt = CountRow2;
					end
					3'd3: begin
						w.push_back(mk(1'b0, RowAddr3));
						char_cnt = CountRow3;
					end
					default: ;
				endcase
				next_sel = {1'b0, line_sel} + 4'd1;
				if (next_sel >= LineWrapMin) begin
					next_sel = {1'b0, LineFirst};
					w.push_back(mk(1'b0, InstrClear));
				end
				line_sel = next_sel[2:0];
			end
			// force row addresses at the count marks, clear past the count limit
			if (char_cnt == CountRow1) begin
				w.push_back(mk(1'b0, RowAddr1));
			end else if (char_cnt == CountRow2) begin
				w.push_back(mk(1'b0, RowAddr2));
			end else if (char_cnt == CountRow3) begin
				w.push_back(mk(1'b0, RowAddr3));
				char_cnt = CountRow0;
			end else if (char_cnt > CountLimit) begin
				char_cnt = CountRow0;
				w.push_back(mk(1'b0, InstrClear));
			end
			// printable codes go out as data
			if (ch > PrintableMin) begin
				w.push_back(mk(1'b1, ch));
				char_cnt = char_cnt + 7'd1;
			end
			if (w.size() > 0)
				w[w.size() - 1].last = 1'b1;
			foreach (w[i])
				pending_q.push_back(w[i]);
		endfunction

		// Compare one accepted write with the oldest expectation
		function void check_write(logic d, logic [7:0] b, logic l);
			lcd_exp_t e;
			if (d)
				data_writes++;
			else
				instr_writes++;
			if (pending_q.size() == 0) begin
				flag($sformatf("unexpected write is_data=%0b byte=%02h last=%0b",
					d, b, l));
				return;
			end
			e = pending_q.pop_front();
			if (d !== e.is_data || b !== e.bus_byte || l !== e.last)
				flag($sformatf({"write mismatch: expected is_data=%0b byte=%02h last=%0b,",
					" got is_data=%0b byte=%02h last=%0b"},
					e.is_data, e.bus_byte, e.last, d, b, l));
		endfunction

		function void close_out();
			while (pending_q.size() > 0) begin
				lcd_exp_t e;
				e = pending_q.pop_front();
				flag($sformatf("missing write is_data=%0b byte=%02h last=%0b",
					e.is_data, e.bus_byte, e.last));
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       cmd = 1'b0;
	logic [7:0] char_code = 8'h00;
	logic [2:0] line_value = 3'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       is_data;
	logic [7:0] bus_byte;
	logic       last;

	lcd_write_book book = new();
	bit            quiet = 1'b0;
	int            sent_cnt = 0;

	char_lcd_text_cursor_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.char_code  (char_code),
		.line_value (line_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.is_data    (is_data),
		.bus_byte   (bus_byte),
		.last       (last)
	);

	always #1 clk = ~clk;

	// Stall the output at random, except during the quiet stretch
	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < IdlePct);
	end

	// Check each write that will be taken at the coming edge
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall)
				book.check_write(is_data, bus_byte, last);
		end
	end

	// Hand one word to the block and hold it until taken
	task automatic push_item(input cmd_t c, input logic [7:0] ch, input logic [2:0] lv);
		bit stalled;
		quiet = (sent_cnt >= 700 && sent_cnt < 1000);
		while (!quiet && $urandom_range(0, 99) < IdlePct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		char_code  <= ch;
		line_value <= lv;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		book.note_item(c, ch, lv);
		sent_cnt++;
	endtask

	task automatic put_char(input logic [7:0] ch);
		push_item(CmdPutChar, ch, 3'($urandom_range(0, 4)));
	endtask

	task automatic set_line(input logic [2:0] lv, input logic [7:0] ch);
		push_item(CmdSetLine, ch, lv);
	endtask

	// Random text: lines of mostly printable characters of varying length
	task automatic run_random();
		int seg;
		int r;
		while (sent_cnt < RandomItems) begin
			seg = $urandom_range(0, 70);
			repeat (seg) begin
				r = $urandom_range(0, 99);
				if (r < 90)
					put_char(8'($urandom_range(8'h1C, 8'hFF)));
				else if (r < 95)
					put_char(8'($urandom_range(8'h00, 8'h1B)));
				else
					put_char(8'($urandom_range(0, 255)));
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				put_char(NewlineCode);
			end else if (r < 85) begin
				set_line(3'($urandom_range(0, 4)), 8'($urandom_range(0, 255)));
			end else begin
				set_line(3'($urandom_range(0, 4)), NewlineCode);
				put_char(NewlineCode);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: code edges, newline from every line, wrap and clear
		put_char(8'h41);
		put_char(PrintableMin);
		put_char(8'h1C);
		put_char(8'hFF);
		put_char(8'h00);
		put_char(NewlineCode);
		put_char(NewlineCode);
		put_char(NewlineCode);
		put_char(NewlineCode);
		put_char(NewlineCode);
		set_line(3'd4, 8'hFF);
		put_char(NewlineCode);
		set_line(3'd0, NewlineCode);
		put_char(NewlineCode);
		set_line(3'd3, 8'h00);
		put_char(8'h5A);
		put_char(NewlineCode);
		put_char(8'h7E);
		set_line(3'd2, 8'h55);
		put_char(8'h0D);
		put_char(NewlineCode);
		put_char(8'h80);

		run_random();
		quiet = 1'b0;
		in_valid <= 1'b0;

		// Drain, then let the back end settle
		while (book.pending_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		book.close_out();

		$display("Covered %0d items (characters, newlines, line loads, control codes).",
			book.items_seen);
		$display("Checked %0d data writes and %0d instruction writes, %0d mismatches.",
			book.data_writes, book.instr_writes, book.mismatches);
		if (book.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Hard stop if the run hangs
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
